>>> src/mac_presence_table_aging_top_macros.svh
// Assertion macros for the presence table RTL.
// Stand-alone header; no dependencies. Empty bodies when SYNTH is defined.
`ifndef MAC_PRESENCE_TABLE_AGING_TOP_MACROS_SVH
`define MAC_PRESENCE_TABLE_AGING_TOP_MACROS_SVH
`ifndef SYNTH
`define MPTA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");
`define MPTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define MPTA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define MPTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> src/mpta_pkg.sv
// Shared constants, codes and state type for the MAC presence table.
// No dependencies.
package mpta_pkg;
	localparam int TABLE_ENTRIES_DEF     = 64;
	localparam int TIME_COUNTER_BITS_DEF = 16;

	localparam logic [7:0]  TTL_RESET    = 8'd20;
	localparam logic [11:0] HEADER_BYTES = 12'd24;

	localparam logic REQ_FRAME = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	localparam logic EVT_NEW   = 1'b0;
	localparam logic EVT_REACT = 1'b1;

	localparam logic REG_TTL_RELOAD = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;
endpackage

>>> src/mpta_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mpta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

>>> src/mac_presence_table_aging_top.sv
// MAC presence table with aging: sequencer, config register and output stage.
// Depends on mpta_pkg, mpta_ram and mac_presence_table_aging_top_macros.svh.
//
// Usage:
//  s_* stream: one beat per request. s_tuser = req_type (0 frame seen, 1 tick).
//  m_* stream: one beat per event (new entry, or offline entry seen again).
//  APB port: register 0 at address 0 is ttl_reload (8 bits, reset 20).
// Timing: every entry lives in one RAM with a registered read port. A tick
//  sweeps all filled slots, reading one entry per cycle and writing the aged
//  entry back the cycle after. A frame scans filled slots until a hit; a miss
//  inserts at the wrapping insert pointer. An event is registered in the output
//  stage. Frames shorter than 24 bytes are dropped in the accept cycle. Slots
//  below the insert pointer (all once it has wrapped) are valid, so reset
//  needs no clear pass.
// Reset: table empty, insert pointer 0, ttl_reload 20, no output pending.
// Stall: an event sits in the m_* register; the block keeps accepting and
//  working on items, and only waits if a second event is ready before the
//  first one has been taken.
module mac_presence_table_aging_top
	import mpta_pkg::*;
#(
	parameter int TABLE_ENTRIES     = TABLE_ENTRIES_DEF,
	parameter int TIME_COUNTER_BITS = TIME_COUNTER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [47:0] source_mac, [59:48] frame_length, [91:60] capture_time, [95:92] zero
	input  logic [95:0] s_tdata,
	// [0] req_type
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [47:0] entry_mac, [53:48] entry_slot, [85:54] entry_capture_time,
	// [86] pointer_wrapped, [87] zero
	output logic [87:0] m_tdata,
	// [0] event_kind
	output logic        m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
`include "mac_presence_table_aging_top_macros.svh"

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = AW + 1;
	localparam int TB = TIME_COUNTER_BITS;
	// entry layout: mac | ttl | offline | online time | first seen
	localparam int TTL_LO = 48;
	localparam int OFF_B  = 56;
	localparam int ONL_LO = 57;
	localparam int FS_LO  = ONL_LO + TB;
	localparam int EW     = FS_LO + 32;

	localparam logic [CW-1:0] N_CNT    = CW'(TABLE_ENTRIES);
	localparam logic [AW-1:0] LAST_PTR = AW'(TABLE_ENTRIES - 1);
	localparam logic [TB-1:0] TIME_MAX = '1;

	state_t state_q, state_d;

	logic [7:0]    ttl_reload_q;
	logic [AW-1:0] ptr_q, ptr_d;
	logic          full_q, full_d;
	logic [CW-1:0] cnt_q, cnt_d, limit;
	logic          vld_s1;
	logic [AW-1:0] addr_s1;

	logic          req_q;
	logic [47:0]   mac_q;
	logic [31:0]   now_q;

	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [EW-1:0] rd_data, wr_data;

	logic          res_load;
	logic          res_kind_d, res_kind_q;
	logic [47:0]   res_mac_d, res_mac_q;
	logic [AW-1:0] res_slot_d, res_slot_q;
	logic [31:0]   res_time_d, res_time_q;
	logic          res_wrap_d, res_wrap_q;
	logic [AW+5:0] res_slot_ext;

	logic          in_acc, out_free, out_load, hit;
	logic [7:0]    ttl_rd, ttl_aged;
	logic          off_rd, off_aged;
	logic [TB-1:0] onl_rd, onl_aged;

	mpta_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TTL_RELOAD) ? {24'd0, ttl_reload_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_reload_q <= TTL_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_TTL_RELOAD) begin
			ttl_reload_q <= pwdata[7:0];
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign limit    = full_q ? N_CNT : {1'b0, ptr_q};
	assign rd_addr  = cnt_q[AW-1:0];

	assign ttl_rd = rd_data[TTL_LO +: 8];
	assign off_rd = rd_data[OFF_B];
	assign onl_rd = rd_data[ONL_LO +: TB];
	assign hit    = (rd_data[47:0] == mac_q);

	// tick aging of the entry just read
	always_comb begin
		onl_aged = onl_rd;
		if (!off_rd && onl_rd != TIME_MAX) begin
			onl_aged = onl_rd + TB'(1);
		end
		if (ttl_rd <= 8'd1) begin
			off_aged = 1'b1;
			ttl_aged = ttl_reload_q;
		end else begin
			off_aged = off_rd;
			ttl_aged = ttl_rd - 8'd1;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		ptr_d      = ptr_q;
		full_d     = full_q;
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = addr_s1;
		wr_data    = rd_data;
		res_load   = 1'b0;
		res_kind_d = EVT_NEW;
		res_mac_d  = rd_data[47:0];
		res_slot_d = addr_s1;
		res_time_d = rd_data[FS_LO +: 32];
		res_wrap_d = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (s_tuser == REQ_TICK || s_tdata[59:48] >= HEADER_BYTES)) begin
					state_d = ST_SCAN;
					cnt_d   = '0;
				end
			end
			ST_SCAN: begin
				if (cnt_q < limit) begin
					rd_en = 1'b1;
					cnt_d = cnt_q + CW'(1);
				end
				if (vld_s1 && req_q == REQ_TICK) begin
					wr_en = 1'b1;
					wr_data[TTL_LO +: 8]  = ttl_aged;
					wr_data[OFF_B]        = off_aged;
					wr_data[ONL_LO +: TB] = onl_aged;
				end else if (vld_s1 && hit) begin
					// sighting: refresh, bring back online if it had aged out
					wr_en = 1'b1;
					wr_data[TTL_LO +: 8] = ttl_reload_q;
					wr_data[OFF_B]       = 1'b0;
					if (off_rd) begin
						wr_data[ONL_LO +: TB] = '0;
						res_load   = 1'b1;
						res_kind_d = EVT_REACT;
						state_d    = ST_EMIT;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (!vld_s1 && cnt_q >= limit) begin
					if (req_q == REQ_TICK) begin
						state_d = ST_IDLE;
					end else begin
						// miss: insert at the pointer
						wr_en      = 1'b1;
						wr_addr    = ptr_q;
						wr_data    = {now_q, {TB{1'b0}}, 1'b0, ttl_reload_q, mac_q};
						res_load   = 1'b1;
						res_kind_d = EVT_NEW;
						res_mac_d  = mac_q;
						res_slot_d = ptr_q;
						res_time_d = now_q;
						res_wrap_d = (ptr_q == LAST_PTR);
						if (ptr_q == LAST_PTR) begin
							ptr_d  = '0;
							full_d = 1'b1;
						end else begin
							ptr_d = ptr_q + AW'(1);
						end
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			ptr_q    <= '0;
			full_q   <= 1'b0;
			vld_s1   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ptr_q   <= ptr_d;
			full_q  <= full_d;
			vld_s1  <= rd_en;
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	assign res_slot_ext = {6'd0, res_slot_q};

	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q[AW-1:0];
		if (in_acc) begin
			req_q <= s_tuser;
			mac_q <= s_tdata[47:0];
			now_q <= s_tdata[91:60];
		end
		if (res_load) begin
			res_kind_q <= res_kind_d;
			res_mac_q  <= res_mac_d;
			res_slot_q <= res_slot_d;
			res_time_q <= res_time_d;
			res_wrap_q <= res_wrap_d;
		end
		if (out_load) begin
			m_tuser <= res_kind_q;
			m_tdata <= {1'b0, res_wrap_q, res_time_q, res_slot_ext[5:0], res_mac_q};
		end
	end

	`MPTA_ASSERT_IMPLY(a_no_rw_same_slot, clk, arst_n, rd_en && wr_en, rd_addr != wr_addr)
	`MPTA_ASSERT_IMPLY(a_wr_in_range, clk, arst_n, wr_en, {1'b0, wr_addr} < N_CNT)
	`MPTA_ASSERT_NEXT(a_full_sticks, clk, arst_n, full_q, full_q)
	`MPTA_ASSERT_NEXT(a_out_drains, clk, arst_n, m_tvalid && m_tready && !out_load, !m_tvalid)
	`MPTA_ASSERT_IMPLY(a_emit_has_slot, clk, arst_n, res_load && res_kind_d == EVT_NEW,
		state_q == ST_SCAN && !vld_s1)
endmodule

>>> tb/mpta_tb_pkg.sv
`timescale 1ns / 1ps
// Prediction and scoreboard for the MAC presence table testbench.
// Depends on mpta_pkg for widths, request and event codes.
package mpta_tb_pkg;
	import mpta_pkg::*;

	localparam int SLOTS       = TABLE_ENTRIES_DEF;
	localparam int ONLINE_BITS = TIME_COUNTER_BITS_DEF;

	// packed in the order kind, mac, slot, first-seen time, wrapped
	typedef struct packed {
		logic        kind;
		logic [47:0] mac;
		logic [5:0]  slot;
		logic [31:0] first_seen;
		logic        wrapped;
	} table_event_t;

	class presence_table_model;
		logic [7:0]             ttl_reload;
		bit                     slot_valid [SLOTS];
		logic [47:0]            slot_mac [SLOTS];
		logic [7:0]             slot_ttl [SLOTS];
		bit                     slot_offline [SLOTS];
		logic [ONLINE_BITS-1:0] slot_online [SLOTS];
		logic [31:0]            slot_first_seen [SLOTS];
		int unsigned            insert_ptr;
		table_event_t           expected_events [$];
		int unsigned            errors;

		function new();
			ttl_reload = TTL_RESET;
			insert_ptr = 0;
			errors = 0;
			foreach (slot_valid[i]) slot_valid[i] = 1'b0;
		endfunction

		function void write_register(int unsigned index, logic [31:0] value);
			if (index == int'(REG_TTL_RELOAD))
				ttl_reload = value[7:0];
		endfunction

		function void note_request(logic req, logic [47:0] mac, logic [11:0] len,
				logic [31:0] now);
			int hit;
			int unsigned slot;
			if (req == REQ_TICK) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!slot_valid[i])
						continue;
					if (!slot_offline[i] && slot_online[i] != '1)
						slot_online[i]++;
					// offline entries keep counting down and get re-marked
					if (slot_ttl[i] <= 8'd1) begin
						slot_offline[i] = 1'b1;
						slot_ttl[i] = ttl_reload;
					end else begin
						slot_ttl[i]--;
					end
				end
				return;
			end
			if (len < HEADER_BYTES)
				return;
			hit = -1;
			for (int i = 0; i < SLOTS; i++)
				if (hit < 0 && slot_valid[i] && slot_mac[i] == mac)
					hit = i;
			if (hit >= 0) begin
				slot_ttl[hit] = ttl_reload;
				if (slot_offline[hit]) begin
					slot_offline[hit] = 1'b0;
					slot_online[hit] = '0;
					expected_events.push_back({EVT_REACT, slot_mac[hit], 6'(hit),
						slot_first_seen[hit], 1'b0});
				end
				return;
			end
			slot = insert_ptr;
			slot_valid[slot] = 1'b1;
			slot_mac[slot] = mac;
			slot_ttl[slot] = ttl_reload;
			slot_offline[slot] = 1'b0;
			slot_online[slot] = '0;
			slot_first_seen[slot] = now;
			insert_ptr = (slot + 1) % SLOTS;
			expected_events.push_back({EVT_NEW, mac, 6'(slot), now, insert_ptr == 0});
		endfunction

		function void compare_field(string field, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t %s: expected %h, got %h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_event(table_event_t got);
			table_event_t want;
			if (expected_events.size() == 0) begin
				$display("%0t unexpected event: expected none, got kind %0d mac %h slot %0d",
					$time, got.kind, got.mac, got.slot);
				errors++;
				return;
			end
			want = expected_events.pop_front();
			compare_field("event_kind", 64'(want.kind), 64'(got.kind));
			compare_field("entry_mac", 64'(want.mac), 64'(got.mac));
			compare_field("entry_slot", 64'(want.slot), 64'(got.slot));
			compare_field("entry_capture_time", 64'(want.first_seen), 64'(got.first_seen));
			compare_field("pointer_wrapped", 64'(want.wrapped), 64'(got.wrapped));
		endfunction
	endclass
endpackage

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for the MAC presence table: stream and APB drivers, monitor,
// directed and random stimulus. Depends on mpta_pkg, mpta_tb_pkg and the RTL top.
module tb_top;
	import mpta_pkg::*;
	import mpta_tb_pkg::*;

	localparam int REG_OUT_OF_MAP  = 1;
	localparam int DRAIN_CYCLES    = 100;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int PHASE_ITEMS     = 222;
	localparam int MAC_POOL_DEPTH  = 96;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;
	logic        m_tuser;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	presence_table_model model;
	table_event_t        observed;
	logic [47:0]         mac_pool [$];
	bit                  sender_idles;
	bit                  final_stretch;
	bit                  hold_request;
	int                  quiet_cycles = 0;

	mac_presence_table_aging_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	assign observed = {m_tuser, m_tdata[47:0], m_tdata[53:48], m_tdata[85:54], m_tdata[86]};

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				model.note_request(s_tuser, s_tdata[47:0], s_tdata[59:48], s_tdata[91:60]);
			if (m_tvalid && m_tready)
				model.check_event(observed);
		end
	end

	// watchdog: cycles in which no beat moves on either stream and no APB access
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("mac_presence_table_aging_top: mismatch");
		$finish;
	end

	// receiver: random stall bursts, one long hold on request, none at the end
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request && !final_stretch) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				m_tready <= 1'b1;
			end else if (!final_stretch && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic offer(logic req, logic [47:0] mac, logic [11:0] len, logic [31:0] now);
		@(negedge clk);
		if (sender_idles && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {4'b0, now, len, mac};
		do @(posedge clk); while (!s_tready);
	endtask

	// all beats in, all events out, then let a trailing tick or lookup finish
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (model.expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(int unsigned index, logic [7:0] value);
		logic [31:0] word;
		word = {24'($urandom_range(0, 32'hFFFFFF)), value};
		wait_idle();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(index) << 2;
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		model.write_register(index, word);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic random_item();
		int unsigned pick;
		logic [47:0] mac;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			offer(REQ_TICK, 48'({$urandom, $urandom}), 12'($urandom), $urandom);
		end else if (pick < 25) begin
			offer(REQ_FRAME, 48'({$urandom, $urandom}), 12'($urandom_range(0, 23)), $urandom);
		end else begin
			if (pick < 45 || mac_pool.size() == 0) begin
				mac = 48'({$urandom, $urandom});
				mac_pool.push_back(mac);
				if (mac_pool.size() > MAC_POOL_DEPTH)
					void'(mac_pool.pop_front());
			end else begin
				mac = mac_pool[$urandom_range(0, mac_pool.size() - 1)];
			end
			offer(REQ_FRAME, mac, 12'($urandom_range(24, 4095)), $urandom);
		end
	endtask

	initial begin
		logic [7:0]  ttl_plan [6];
		logic [47:0] fresh_mac;
		ttl_plan = '{8'd255, 8'd2, 8'd1, 8'd0, 8'd7, 8'($urandom_range(1, 255))};
		model = new();
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tuser       = 1'b0;
		s_tdata       = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		sender_idles  = 1'b1;
		final_stretch = 1'b0;
		hold_request  = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// a write past the only register must leave the TTL at its reset value
		write_reg(REG_OUT_OF_MAP, 8'd1);
		offer(REQ_FRAME, '1, 12'd23, 32'h1234_5678);
		offer(REQ_FRAME, '1, 12'd24, '1);
		offer(REQ_FRAME, '0, 12'd4095, '0);
		offer(REQ_FRAME, '0, 12'd100, 32'h0000_0042);
		offer(REQ_FRAME, '0, 12'd0, '0);
		offer(REQ_TICK, '1, '1, '1);
		offer(REQ_TICK, '0, '0, '0);
		offer(REQ_FRAME, '0, 12'd24, 32'h0000_0007);

		// TTL of one: a sighted entry goes offline at the next tick
		write_reg(int'(REG_TTL_RELOAD), 8'd1);
		offer(REQ_TICK, 48'({$urandom, $urandom}), 12'($urandom), $urandom);
		offer(REQ_FRAME, '1, 12'd64, $urandom);
		offer(REQ_TICK, 48'({$urandom, $urandom}), 12'($urandom), $urandom);
		offer(REQ_FRAME, '0, 12'd64, $urandom);

		// TTL of zero behaves like one
		write_reg(int'(REG_TTL_RELOAD), 8'd0);
		fresh_mac = 48'({$urandom, $urandom});
		offer(REQ_FRAME, fresh_mac, 12'd1500, $urandom);
		offer(REQ_TICK, 48'({$urandom, $urandom}), 12'($urandom), $urandom);
		offer(REQ_FRAME, fresh_mac, 12'd60, $urandom);
		offer(REQ_FRAME, fresh_mac, 12'd60, $urandom);

		foreach (ttl_plan[p]) begin
			write_reg(int'(REG_TTL_RELOAD), ttl_plan[p]);
			if (p == 5) begin
				sender_idles  = 1'b0;
				final_stretch = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold the event stream off while beats keep coming in
				if (p == 1 && n == 100)
					hold_request = 1'b1;
				random_item();
			end
		end

		wait_idle();
		if (model.errors == 0 && model.expected_events.size() == 0)
			$display("mac_presence_table_aging_top: match");
		else
			$display("mac_presence_table_aging_top: mismatch");
		$finish;
	end
endmodule
